@@ hw/rtl/sha256_pkg.sv @@
// SHA-256 hasher package: round constants, initial hash values, state type.
// No dependencies; used by sha256_stream_hasher.
package sha256_pkg;

  typedef enum logic [2:0] {
    StIdle,
    StLoad,
    StRound,
    StFinal,
    StOut
  } state_e;

  typedef logic [31:0] word_t;

  localparam logic [7:0] PadByte = 8'h80;
  localparam int unsigned LenPos = 56;

  function automatic word_t init_word(input logic [2:0] idx);
    word_t w;
    w = '0;
    unique case (idx)
      3'd0: w = 32'h6a09e667;
      3'd1: w = 32'hbb67ae85;
      3'd2: w = 32'h3c6ef372;
      3'd3: w = 32'ha54ff53a;
      3'd4: w = 32'h510e527f;
      3'd5: w = 32'h9b05688c;
      3'd6: w = 32'h1f83d9ab;
      3'd7: w = 32'h5be0cd19;
      default: w = '0;
    endcase
    return w;
  endfunction

  function automatic word_t round_const(input logic [5:0] idx);
    localparam word_t K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    return K[idx];
  endfunction

  function automatic word_t rotr(input word_t x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

@@ hw/rtl/sha256_stream_hasher.sv @@
// SHA-256 streaming hasher, one message byte per transaction.
// Depends on sha256_pkg and sha256_ram (16 x 32-bit block memory).
// A byte is taken while idle; a byte that fills a block starts a compression: a load
// state that reads ahead, then one round per cycle. A final transaction fills the rest of
// the block with padding, then compresses each padding block, one or two, the second
// after another fill pass; the digest is registered from StOut once the output is free.
// The single round unit holds the input during each compression and fill pass. Bytes are taken
// while a digest waits; a new digest holds until the previous one has gone.
// Reset: chaining words to the initial hash values, counters to zero, no output.
module sha256_stream_hasher (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [7:0]   s_axis_tdata_i,   // [7:0] data_byte
  input  logic         s_axis_tuser_i,   // byte_present
  input  logic         s_axis_tlast_i,   // message_end
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // [63:0] digest_bits_255_192, [127:64] digest_bits_191_128,
  // [191:128] digest_bits_127_64, [255:192] digest_bits_63_0
  output logic [255:0] m_axis_tdata_o
);
  import sha256_pkg::*;

  state_e state_q, state_d;

  // Memory holds 16 schedule words; a word is assembled in a shift register, then written.
  logic        we;
  logic [3:0]  waddr, raddr;
  logic [31:0] wdata, rdata;

  sha256_ram #(.Width(32), .Depth(16)) u_wmem (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  word_t       h_q [8];
  word_t       v_q [8];
  word_t       wwin_q [16];  // sliding schedule window
  logic [23:0] part_q;       // bytes of the word being built
  logic [5:0]  fill_q;
  logic [63:0] bits_q;
  logic [63:0] total_q;
  logic [6:0]  rnd_q;
  logic        final_q;      // message end taken, digest pending
  logic        second_q;     // another padding block follows
  logic        len_blk_q;    // current fill pass writes the length
  logic        pad_blk_q;    // compressing a padding block
  logic        out_v_q;
  logic [255:0] out_q;

  logic        acc;
  logic        out_free;
  assign s_axis_tready_o = (state_q == StIdle);
  assign acc = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !out_v_q || m_axis_tready_i;
  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = out_q;

  // byte written in the fill pass
  logic [7:0] pad_byte;
  always_comb begin
    pad_byte = 8'h00;
    if (len_blk_q && fill_q >= 6'(LenPos)) begin
      pad_byte = total_q[8 * (7 - fill_q[2:0]) +: 8];
    end else if (fill_q == total_q[8:3]) begin
      pad_byte = PadByte;
    end
  end

  logic [7:0] in_byte;
  logic       byte_we;
  always_comb begin
    in_byte = (state_q == StFinal) ? pad_byte : s_axis_tdata_i;
    byte_we = (acc && s_axis_tuser_i) || (state_q == StFinal);
  end

  assign we    = byte_we && (fill_q[1:0] == 2'd3);
  assign waddr = fill_q[5:2];
  assign wdata = {part_q, in_byte};
  assign raddr = rnd_q[3:0];

  // round datapath
  word_t w_cur, s0, s1, w_new, t1, t2, big0, big1, ch, maj;
  always_comb begin
    s0 = rotr(wwin_q[1], 7) ^ rotr(wwin_q[1], 18) ^ (wwin_q[1] >> 3);
    s1 = rotr(wwin_q[14], 17) ^ rotr(wwin_q[14], 19) ^ (wwin_q[14] >> 10);
    w_new = s1 + wwin_q[9] + s0 + wwin_q[0];
    w_cur = (rnd_q < 7'd17) ? rdata : w_new;
    big1 = rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25);
    ch   = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
    big0 = rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22);
    maj  = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
    t1   = v_q[7] + big1 + ch + round_const(6'(rnd_q - 7'd1)) + w_cur;
    t2   = big0 + maj;
  end

  // total bits including the last partial block and this transaction's byte
  logic [5:0]  fill_nx;
  logic        blk_full;
  always_comb begin
    fill_nx  = fill_q + 6'(acc && s_axis_tuser_i);
    blk_full = acc && s_axis_tuser_i && (fill_q == 6'd63);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (acc) begin
          if (blk_full) begin
            state_d = StLoad;
          end else if (s_axis_tlast_i) begin
            state_d = StFinal;
          end
        end
      end
      StLoad:  state_d = StRound;
      StRound: begin
        if (rnd_q == 7'd64) begin
          if (!final_q) state_d = StIdle;
          else if (pad_blk_q && !second_q) state_d = StOut;
          else state_d = StFinal;
        end
      end
      StFinal: if (fill_q == 6'd63) state_d = StLoad;
      StOut:   if (out_free) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      part_q    <= '0;
      fill_q    <= '0;
      bits_q    <= '0;
      total_q   <= '0;
      rnd_q     <= '0;
      final_q   <= 1'b0;
      second_q  <= 1'b0;
      len_blk_q <= 1'b0;
      pad_blk_q <= 1'b0;
      out_v_q   <= 1'b0;
      out_q     <= '0;
      for (int i = 0; i < 8; i++) begin
        h_q[i] <= init_word(3'(i));
        v_q[i] <= '0;
      end
      for (int i = 0; i < 16; i++) wwin_q[i] <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == StOut && out_free) out_v_q <= 1'b1;
      else if (m_axis_tready_i) out_v_q <= 1'b0;
      if (byte_we) begin
        part_q <= {part_q[15:0], in_byte};
        fill_q <= fill_q + 6'd1;
      end
      unique case (state_q)
        StIdle: begin
          if (acc) begin
            if (blk_full) bits_q <= bits_q + 64'd512;
            if (s_axis_tlast_i) begin
              final_q <= 1'b1;
              // a just-completed block shows as fill_nx wrapping to zero
              total_q <= (blk_full ? bits_q + 64'd512 : bits_q) + {55'd0, fill_nx, 3'b000};
              second_q  <= (fill_nx >= 6'd56);
              len_blk_q <= (fill_nx < 6'd56);
            end
          end
          rnd_q <= '0;
        end
        StLoad: begin
          rnd_q <= 7'd1;
          for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
        end
        StRound: begin
          rnd_q <= (rnd_q == 7'd64) ? '0 : rnd_q + 7'd1;
          for (int i = 0; i < 15; i++) wwin_q[i] <= wwin_q[i + 1];
          wwin_q[15] <= w_cur;
          v_q[7] <= v_q[6];
          v_q[6] <= v_q[5];
          v_q[5] <= v_q[4];
          v_q[4] <= v_q[3] + t1;
          v_q[3] <= v_q[2];
          v_q[2] <= v_q[1];
          v_q[1] <= v_q[0];
          v_q[0] <= t1 + t2;
          if (rnd_q == 7'd64) begin
            h_q[0] <= h_q[0] + t1 + t2;
            h_q[1] <= h_q[1] + v_q[0];
            h_q[2] <= h_q[2] + v_q[1];
            h_q[3] <= h_q[3] + v_q[2];
            h_q[4] <= h_q[4] + v_q[3] + t1;
            h_q[5] <= h_q[5] + v_q[4];
            h_q[6] <= h_q[6] + v_q[5];
            h_q[7] <= h_q[7] + v_q[6];
            if (final_q && second_q) begin
              // pad byte already placed in the first padding block
              second_q  <= 1'b0;
              len_blk_q <= 1'b1;
            end
          end
        end
        StFinal: begin
          rnd_q     <= '0;
          pad_blk_q <= 1'b1;
        end
        StOut: begin
          if (out_free) begin
            // lowest tdata bits carry digest bytes 0..7 with byte 0 highest
            out_q <= {h_q[6], h_q[7], h_q[4], h_q[5], h_q[2], h_q[3], h_q[0], h_q[1]};
            for (int i = 0; i < 8; i++) h_q[i] <= init_word(3'(i));
            bits_q    <= '0;
            fill_q    <= '0;
            final_q   <= 1'b0;
            len_blk_q <= 1'b0;
            pad_blk_q <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

@@ hw/rtl/sha256_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module sha256_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
